// ===== sv/tcau_pkg.sv =====
// ----------------------------------------------------------------------------
// Time counter arithmetic unit - shared definitions
// Field widths, radix constants, operation codes and the item structs used
// across the normaliser, the arithmetic stage and the top level.
// ----------------------------------------------------------------------------
package tcau_pkg;

  localparam int TicksPerSecond = 1000;
  localparam int HourBitsDefault = 16;
  localparam int Radix60 = 60;

  localparam int HourPortW = 16;
  localparam int MinW = 6;
  localparam int SecW = 6;
  localparam int TickW = 10;
  localparam int OrderW = 2;
  localparam int OpW = 3;

  localparam int TickSumW = TickW + 1;
  localparam int SecSumW2 = SecW + 1;
  localparam int MinSumW2 = MinW + 1;

  // Stream packing
  localparam int InFieldsW = 2 * (HourPortW + MinW + SecW + TickW);
  localparam int InDataW = ((InFieldsW + 7) / 8) * 8;
  localparam int OutFieldsW = HourPortW + MinW + SecW + TickW + OrderW;
  localparam int OutDataW = ((OutFieldsW + 7) / 8) * 8;

  // Reciprocal for ticks / TicksPerSecond; the estimate is low by at most one
  localparam int RecipShift = 20;
  localparam int RecipW = RecipShift;
  localparam int TickRecip = (1 << RecipShift) / TicksPerSecond;

  // Bounds for carrying up raw operand fields
  localparam int TickRawMax = (1 << TickW) - 1;
  localparam int SecSumMax = (1 << SecW) - 1 + TickRawMax / TicksPerSecond;
  localparam int SecSumW = $clog2(SecSumMax + 1);
  localparam int SecCarryMax = SecSumMax / Radix60;
  localparam int SecCarryW = $clog2(SecCarryMax + 1);
  localparam int MinSumW = $clog2((1 << MinW) + SecCarryMax);

  localparam logic [OrderW-1:0] OrderLess = 2'b11;
  localparam logic [OrderW-1:0] OrderEqual = 2'b00;
  localparam logic [OrderW-1:0] OrderGreater = 2'b01;

  typedef enum logic [OpW-1:0] {
    OpTick    = 3'd0,
    OpRead    = 3'd1,
    OpAdd     = 3'd2,
    OpSub     = 3'd3,
    OpDiff    = 3'd4,
    OpCompare = 3'd5
  } op_e;

  typedef struct packed {
    logic [MinW-1:0]  minutes;
    logic [SecW-1:0]  seconds;
    logic [TickW-1:0] ticks;
  } hms_t;

  typedef struct packed {
    logic valid;
    op_e  op;
  } stage_t;

  typedef struct packed {
    logic [HourPortW-1:0] hours;
    hms_t                 hms;
    logic [OrderW-1:0]    order;
    logic                 error;
  } res_t;

endpackage

// ===== sv/tcau_norm.sv =====
// ----------------------------------------------------------------------------
// Operand normaliser
// Carries raw tick, second and minute fields upward so that every field is
// below its radix. Two register stages: tick quotient estimate, then carry.
// ----------------------------------------------------------------------------
module tcau_norm #(
  parameter int HourBits = tcau_pkg::HourBitsDefault
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [HourBits-1:0] hours_i,
  input  tcau_pkg::hms_t      hms_i,
  output logic [HourBits-1:0] hours_o,
  output tcau_pkg::hms_t      hms_o
);
  import tcau_pkg::*;

  localparam int ProdW = TickW + RecipW;

  logic [ProdW-1:0]    prod;
  logic [TickW-1:0]    quot_d, quot_q;
  logic [HourBits-1:0] hours_q, hours_d;
  hms_t                raw_q, norm_d;

  logic [TickSumW-1:0]  tick_rem, tick_fix;
  logic [TickW-1:0]     quot_fix;
  logic [SecSumW-1:0]   sec_sum, sec_base;
  logic [SecCarryW-1:0] sec_carry;
  logic [MinSumW-1:0]   min_sum;
  logic                 hour_carry;

  // ticks * (2^RecipShift / TicksPerSecond), top bits give the quotient
  assign prod = ProdW'(hms_i.ticks) * ProdW'(TickRecip);
  assign quot_d = prod[ProdW-1 -: TickW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q  <= quot_d;
      hours_q <= hours_i;
      raw_q   <= hms_i;
    end
  end

  always_comb begin
    tick_rem = TickSumW'(raw_q.ticks) - TickSumW'(quot_q) * TickSumW'(TicksPerSecond);
    tick_fix = tick_rem;
    quot_fix = quot_q;
    if (tick_rem >= TickSumW'(TicksPerSecond)) begin
      tick_fix = tick_rem - TickSumW'(TicksPerSecond);
      quot_fix = quot_q + 1'b1;
    end

    sec_sum   = SecSumW'(raw_q.seconds) + SecSumW'(quot_fix);
    sec_carry = '0;
    sec_base  = '0;
    // thermometer of multiples of sixty
    for (int k = 1; k <= SecCarryMax; k++) begin
      if (sec_sum >= SecSumW'(k * Radix60)) begin
        sec_carry = SecCarryW'(k);
        sec_base  = SecSumW'(k * Radix60);
      end
    end

    min_sum    = MinSumW'(raw_q.minutes) + MinSumW'(sec_carry);
    hour_carry = (min_sum >= MinSumW'(Radix60));

    norm_d.ticks   = TickW'(tick_fix);
    norm_d.seconds = SecW'(sec_sum - sec_base);
    norm_d.minutes = hour_carry ? MinW'(min_sum - MinSumW'(Radix60)) : MinW'(min_sum);
    hours_d        = hours_q + HourBits'(hour_carry);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hours_o <= hours_d;
      hms_o   <= norm_d;
    end
  end

endmodule

// ===== sv/tcau_alu.sv =====
// ----------------------------------------------------------------------------
// Time arithmetic stage
// Holds the running time, performs tick/read/add/subtract/difference/compare
// on normalised operands and registers the result item.
// ----------------------------------------------------------------------------
module tcau_alu #(
  parameter int HourBits = tcau_pkg::HourBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  tcau_pkg::stage_t    stage_i,
  input  logic [HourBits-1:0] a_hours_i,
  input  tcau_pkg::hms_t      a_hms_i,
  input  logic [HourBits-1:0] b_hours_i,
  input  tcau_pkg::hms_t      b_hms_i,
  output logic                valid_o,
  output tcau_pkg::res_t      res_o
);
  import tcau_pkg::*;

  logic [HourBits-1:0] now_hours_q, now_hours_d;
  hms_t                now_hms_q, now_hms_d;
  logic                valid_q;
  res_t                res_q, res_d;

  logic a_gt, a_lt;

  // add path
  logic [TickSumW-1:0] add_t;
  logic [SecSumW2-1:0] add_s;
  logic [MinSumW2-1:0] add_m;
  logic                add_ct, add_cs, add_cm;
  hms_t                add_hms;
  logic [HourBits-1:0] add_hours;

  // subtract path, larger operand first
  logic [HourBits-1:0] x_hours, y_hours, sub_hours;
  hms_t                x_hms, y_hms, sub_hms;
  logic [TickSumW-1:0] dif_t;
  logic [SecSumW2-1:0] dif_s;
  logic [MinSumW2-1:0] dif_m;
  logic                bor_t, bor_s, bor_m;

  // tick path
  logic wrap_t, wrap_s, wrap_m;

  logic [HourBits-1:0] res_hours;

  assign a_gt = {a_hours_i, a_hms_i} > {b_hours_i, b_hms_i};
  assign a_lt = {a_hours_i, a_hms_i} < {b_hours_i, b_hms_i};

  always_comb begin
    add_t  = TickSumW'(a_hms_i.ticks) + TickSumW'(b_hms_i.ticks);
    add_ct = (add_t >= TickSumW'(TicksPerSecond));
    add_hms.ticks = TickW'(add_ct ? add_t - TickSumW'(TicksPerSecond) : add_t);
    add_s  = SecSumW2'(a_hms_i.seconds) + SecSumW2'(b_hms_i.seconds) + SecSumW2'(add_ct);
    add_cs = (add_s >= SecSumW2'(Radix60));
    add_hms.seconds = SecW'(add_cs ? add_s - SecSumW2'(Radix60) : add_s);
    add_m  = MinSumW2'(a_hms_i.minutes) + MinSumW2'(b_hms_i.minutes) + MinSumW2'(add_cs);
    add_cm = (add_m >= MinSumW2'(Radix60));
    add_hms.minutes = MinW'(add_cm ? add_m - MinSumW2'(Radix60) : add_m);
    add_hours = a_hours_i + b_hours_i + HourBits'(add_cm);
  end

  always_comb begin
    x_hours = a_lt ? b_hours_i : a_hours_i;
    y_hours = a_lt ? a_hours_i : b_hours_i;
    x_hms   = a_lt ? b_hms_i : a_hms_i;
    y_hms   = a_lt ? a_hms_i : b_hms_i;

    dif_t = TickSumW'(x_hms.ticks) - TickSumW'(y_hms.ticks);
    bor_t = dif_t[TickSumW-1];
    sub_hms.ticks = TickW'(bor_t ? dif_t + TickSumW'(TicksPerSecond) : dif_t);
    dif_s = SecSumW2'(x_hms.seconds) - SecSumW2'(y_hms.seconds) - SecSumW2'(bor_t);
    bor_s = dif_s[SecSumW2-1];
    sub_hms.seconds = SecW'(bor_s ? dif_s + SecSumW2'(Radix60) : dif_s);
    dif_m = MinSumW2'(x_hms.minutes) - MinSumW2'(y_hms.minutes) - MinSumW2'(bor_s);
    bor_m = dif_m[MinSumW2-1];
    sub_hms.minutes = MinW'(bor_m ? dif_m + MinSumW2'(Radix60) : dif_m);
    sub_hours = x_hours - y_hours - HourBits'(bor_m);
  end

  always_comb begin
    wrap_t = (now_hms_q.ticks == TickW'(TicksPerSecond - 1));
    wrap_s = wrap_t && (now_hms_q.seconds == SecW'(Radix60 - 1));
    wrap_m = wrap_s && (now_hms_q.minutes == MinW'(Radix60 - 1));
    now_hms_d.ticks   = wrap_t ? '0 : now_hms_q.ticks + 1'b1;
    now_hms_d.seconds = wrap_t ? (wrap_s ? '0 : now_hms_q.seconds + 1'b1) : now_hms_q.seconds;
    now_hms_d.minutes = wrap_s ? (wrap_m ? '0 : now_hms_q.minutes + 1'b1) : now_hms_q.minutes;
    now_hours_d       = now_hours_q + HourBits'(wrap_m);
  end

  always_comb begin
    res_d     = '0;
    res_hours = '0;
    case (stage_i.op)
      OpTick: begin
        res_hours = now_hours_d;
        res_d.hms = now_hms_d;
      end
      OpRead: begin
        res_hours = now_hours_q;
        res_d.hms = now_hms_q;
      end
      OpAdd: begin
        res_hours = add_hours;
        res_d.hms = add_hms;
      end
      OpSub: begin
        if (a_gt) begin
          res_hours = sub_hours;
          res_d.hms = sub_hms;
        end else begin
          res_d.error = 1'b1;
        end
      end
      OpDiff: begin
        res_hours = sub_hours;
        res_d.hms = sub_hms;
      end
      OpCompare: begin
        res_d.order = a_gt ? OrderGreater : (a_lt ? OrderLess : OrderEqual);
      end
      default: begin
      end
    endcase
    res_d.hours = HourPortW'(res_hours);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_hours_q <= '0;
      now_hms_q   <= '0;
      valid_q     <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
      if (stage_i.valid && stage_i.op == OpTick) begin
        now_hours_q <= now_hours_d;
        now_hms_q   <= now_hms_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  a_now_normalised: assert property (@(posedge clk_i) disable iff (!rst_ni)
    now_hms_q.ticks < TickW'(TicksPerSecond) && now_hms_q.seconds < SecW'(Radix60) &&
    now_hms_q.minutes < MinW'(Radix60))
    else $error("stored time left normalised range");

  a_now_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(now_hms_q) && $stable(now_hours_q))
    else $error("stored time changed while pipeline stalled");

  a_result_normalised: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> res_q.hms.ticks < TickW'(TicksPerSecond) &&
    res_q.hms.seconds < SecW'(Radix60) && res_q.hms.minutes < MinW'(Radix60))
    else $error("result time not normalised");

  a_error_zero_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && res_q.error |-> res_q.hms == '0 && res_q.hours == '0 &&
    res_q.order == OrderEqual)
    else $error("failed subtract carries a non-zero result");

  a_order_zero_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && res_q.order != OrderEqual |-> res_q.hms == '0 && res_q.hours == '0 &&
    !res_q.error)
    else $error("compare result carries a time");

endmodule

// ===== sv/time_counter_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Time counter arithmetic unit
// Running hours/minutes/seconds/ticks time with add, subtract, difference and
// compare on two operand times.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, two normaliser stages and
//   the arithmetic stage into the result register.
// Throughput: one item per cycle; the whole pipeline holds while a result
//   waits on m_axis_tready, so s_axis_tready falls only then.
// Reset: stored time cleared to zero, pipeline emptied.
module time_counter_arithmetic_unit #(
  parameter int HourBits = tcau_pkg::HourBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // a_hours, a_minutes, a_seconds, a_ticks, b_hours, b_minutes, b_seconds,
  // b_ticks, zero pad
  input  logic [tcau_pkg::InDataW-1:0]   s_axis_tdata,
  // operation
  input  logic [tcau_pkg::OpW-1:0]       s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // res_hours, res_minutes, res_seconds, res_ticks, order
  output logic [tcau_pkg::OutDataW-1:0]  m_axis_tdata,
  // error
  output logic                           m_axis_tuser
);
  import tcau_pkg::*;

  logic pipe_en, out_valid;
  stage_t st0_q, st1_q, st2_q;

  logic [HourPortW-1:0] a_hours_q, b_hours_q;
  hms_t                 a_hms_q, b_hms_q;
  logic [HourBits-1:0]  a_hours_n, b_hours_n;
  hms_t                 a_hms_n, b_hms_n;
  res_t                 res;

  assign pipe_en       = !out_valid || m_axis_tready;
  assign s_axis_tready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st0_q <= '0;
      st1_q <= '0;
      st2_q <= '0;
    end else if (pipe_en) begin
      st0_q.valid <= s_axis_tvalid;
      st0_q.op    <= op_e'(s_axis_tuser);
      st1_q       <= st0_q;
      st2_q       <= st1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_hours_q       <= s_axis_tdata[15:0];
      a_hms_q.minutes <= s_axis_tdata[21:16];
      a_hms_q.seconds <= s_axis_tdata[27:22];
      a_hms_q.ticks   <= s_axis_tdata[37:28];
      b_hours_q       <= s_axis_tdata[53:38];
      b_hms_q.minutes <= s_axis_tdata[59:54];
      b_hms_q.seconds <= s_axis_tdata[65:60];
      b_hms_q.ticks   <= s_axis_tdata[75:66];
    end
  end

  tcau_norm #(.HourBits(HourBits)) u_norm_a (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .hours_i (HourBits'(a_hours_q)),
    .hms_i   (a_hms_q),
    .hours_o (a_hours_n),
    .hms_o   (a_hms_n)
  );

  tcau_norm #(.HourBits(HourBits)) u_norm_b (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .hours_i (HourBits'(b_hours_q)),
    .hms_i   (b_hms_q),
    .hours_o (b_hours_n),
    .hms_o   (b_hms_n)
  );

  tcau_alu #(.HourBits(HourBits)) u_alu (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (pipe_en),
    .stage_i   (st2_q),
    .a_hours_i (a_hours_n),
    .a_hms_i   (a_hms_n),
    .b_hours_i (b_hours_n),
    .b_hms_i   (b_hms_n),
    .valid_o   (out_valid),
    .res_o     (res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {res.order, res.hms.ticks, res.hms.seconds, res.hms.minutes,
                          res.hours};
  assign m_axis_tuser  = res.error;

endmodule

// ===== tb/tb_time_counter_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Time counter arithmetic unit - self-checking testbench
// The source side sends operation items: a directed set, a random mix, a
// back-to-back run of ticks with a read now and then, then a second random
// mix. A predictor keeps its own copy of the running time. Every item taken
// at the input queues the expected result, and each result item is checked
// field by field against the oldest one. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_time_counter_arithmetic_unit;
  import tcau_pkg::*;

  // codes with no operation behind them
  localparam logic [OpW-1:0] OpSpareLo = 3'd6;
  localparam logic [OpW-1:0] OpSpareHi = 3'd7;

  localparam longint unsigned HourMask = (64'd1 << HourBitsDefault) - 64'd1;

  // result item layout in m_axis_tdata
  localparam int ResMinLo = HourPortW;
  localparam int ResSecLo = ResMinLo + MinW;
  localparam int ResTickLo = ResSecLo + SecW;
  localparam int ResOrderLo = ResTickLo + TickW;

  localparam int TickRunLen = 100;
  localparam int RandomLen = 420;
  localparam int LongHoldAt = 100;
  localparam int LongHoldLen = 60;
  localparam longint TimeLimit = 64'd4000000;

  // one operand as it sits on the bus; hours in the low bits
  typedef struct packed {
    logic [TickW-1:0]     t;
    logic [SecW-1:0]      s;
    logic [MinW-1:0]      m;
    logic [HourPortW-1:0] h;
  } operand_t;

  typedef struct {
    longint unsigned h, m, s, t;
  } span_t;

  typedef struct {
    logic [OpW-1:0] op;
    operand_t       a, b;
    bit             may_idle;
    bit             drain_first;
  } job_t;

  typedef struct {
    logic [HourPortW-1:0] hours;
    logic [MinW-1:0]      minutes;
    logic [SecW-1:0]      seconds;
    logic [TickW-1:0]     ticks;
    logic [OrderW-1:0]    order;
    logic                 error;
  } outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [OpW-1:0]      s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  job_t     pending_items[$];
  outcome_t due_results[$];
  span_t    now_span;
  int       fail_count = 0;
  int       results_seen = 0;
  bit       in_accept = 1'b0;
  bit       pace_quiet = 1'b0;
  int       gap_left = 0;
  int       hold_left = 0;
  bit       long_hold_done = 1'b0;

  time_counter_arithmetic_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic span_t carry_span(span_t x);
    x.s += x.t / TicksPerSecond;
    x.t %= TicksPerSecond;
    x.m += x.s / Radix60;
    x.s %= Radix60;
    x.h += x.m / Radix60;
    x.m %= Radix60;
    x.h &= HourMask;
    return x;
  endfunction

  function automatic span_t widen(operand_t x);
    span_t w;
    w.h = 64'(x.h);
    w.m = 64'(x.m);
    w.s = 64'(x.s);
    w.t = 64'(x.t);
    return carry_span(w);
  endfunction

  function automatic int order_spans(span_t a, span_t b);
    if (a.h != b.h) return (a.h > b.h) ? 1 : -1;
    if (a.m != b.m) return (a.m > b.m) ? 1 : -1;
    if (a.s != b.s) return (a.s > b.s) ? 1 : -1;
    if (a.t != b.t) return (a.t > b.t) ? 1 : -1;
    return 0;
  endfunction

  function automatic span_t borrow_sub(span_t a, span_t b);
    span_t r;
    longint unsigned bw;
    if (a.t < b.t) begin
      r.t = a.t + TicksPerSecond - b.t;
      bw = 1;
    end else begin
      r.t = a.t - b.t;
      bw = 0;
    end
    if (a.s < b.s + bw) begin
      r.s = a.s + Radix60 - b.s - bw;
      bw = 1;
    end else begin
      r.s = a.s - b.s - bw;
      bw = 0;
    end
    if (a.m < b.m + bw) begin
      r.m = a.m + Radix60 - b.m - bw;
      bw = 1;
    end else begin
      r.m = a.m - b.m - bw;
      bw = 0;
    end
    r.h = (a.h - b.h - bw) & HourMask;
    return r;
  endfunction

  // works out the result of one item and advances the running time on a tick
  function automatic outcome_t predict_result(job_t j);
    span_t    a, b, r;
    outcome_t o;
    int       c;
    a = widen(j.a);
    b = widen(j.b);
    r = '{0, 0, 0, 0};
    c = order_spans(a, b);
    o.order = OrderEqual;
    o.error = 1'b0;
    case (j.op)
      OpTick: begin
        r = now_span;
        r.t += 1;
        r = carry_span(r);
        now_span = r;
      end
      OpRead: r = now_span;
      OpAdd: begin
        r.h = a.h + b.h;
        r.m = a.m + b.m;
        r.s = a.s + b.s;
        r.t = a.t + b.t;
        r = carry_span(r);
      end
      OpSub: begin
        if (c > 0) r = borrow_sub(a, b);
        else o.error = 1'b1;
      end
      OpDiff: r = (c < 0) ? borrow_sub(b, a) : borrow_sub(a, b);
      OpCompare: begin
        o.order = (c < 0) ? OrderLess : ((c > 0) ? OrderGreater : OrderEqual);
      end
      default: ;
    endcase
    o.hours = HourPortW'(r.h);
    o.minutes = MinW'(r.m);
    o.seconds = SecW'(r.s);
    o.ticks = TickW'(r.t);
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic operand_t hms(int h, int m, int s, int t);
    operand_t x;
    x.h = HourPortW'(h);
    x.m = MinW'(m);
    x.s = SecW'(s);
    x.t = TickW'(t);
    return x;
  endfunction

  function automatic operand_t norm_operand();
    operand_t x;
    // small hours now and then so that lower fields decide the order
    x.h = HourPortW'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) :
                                                   $urandom_range(0, 65535));
    x.m = MinW'($urandom_range(0, 59));
    x.s = SecW'($urandom_range(0, 59));
    x.t = TickW'($urandom_range(0, 999));
    return x;
  endfunction

  // any bit pattern, fields at or above their radix included
  function automatic operand_t raw_operand();
    operand_t x;
    x.h = HourPortW'($urandom_range(0, 65535));
    x.m = MinW'($urandom_range(0, 63));
    x.s = SecW'($urandom_range(0, 63));
    x.t = TickW'($urandom_range(0, 1023));
    return x;
  endfunction

  function automatic job_t random_job(bit may_idle);
    job_t     j;
    operand_t tmp;
    int       sel;
    int       rel;
    sel = $urandom_range(0, 19);
    if (sel < 5) j.op = OpTick;
    else if (sel < 7) j.op = OpRead;
    else if (sel < 10) j.op = OpAdd;
    else if (sel < 13) j.op = OpSub;
    else if (sel < 16) j.op = OpDiff;
    else if (sel < 19) j.op = OpCompare;
    else j.op = ($urandom_range(0, 1) != 0) ? OpSpareHi : OpSpareLo;
    j.a = ($urandom_range(0, 9) == 0) ? raw_operand() : norm_operand();
    rel = $urandom_range(0, 5);
    j.b = j.a;
    if (rel == 1) begin
      case ($urandom_range(0, 3))
        0: j.b.h = HourPortW'($urandom_range(0, 65535));
        1: j.b.m = MinW'($urandom_range(0, 59));
        2: j.b.s = SecW'($urandom_range(0, 59));
        default: j.b.t = TickW'($urandom_range(0, 999));
      endcase
    end else if (rel >= 2) begin
      j.b = ($urandom_range(0, 9) == 0) ? raw_operand() : norm_operand();
    end
    // subtract mostly with a above b, so the borrow path gets the bulk
    if (j.op == OpSub && rel >= 3 && order_spans(widen(j.a), widen(j.b)) < 0) begin
      tmp = j.a;
      j.a = j.b;
      j.b = tmp;
    end
    j.may_idle = may_idle;
    j.drain_first = 1'b0;
    return j;
  endfunction

  task automatic queue_item(logic [OpW-1:0] op, operand_t a, operand_t b);
    job_t j;
    j.op = op;
    j.a = a;
    j.b = b;
    j.may_idle = 1'b1;
    j.drain_first = 1'b0;
    pending_items.push_back(j);
  endtask

  // ---------------------------------------------------------------- source
  always @(negedge clk_i) begin : source_drive
    job_t               j;
    logic [InDataW-1:0] w;
    if (rst_ni && !(s_axis_tvalid && !in_accept)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() != 0 &&
                   !(pending_items[0].drain_first && due_results.size() != 0)) begin
        j = pending_items.pop_front();
        w = '0;
        w[InFieldsW-1:0] = {j.b, j.a};
        s_axis_tdata <= w;
        s_axis_tuser <= j.op;
        s_axis_tvalid <= 1'b1;
        pace_quiet <= !j.may_idle;
        if (j.may_idle && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 19);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- sink
  always @(negedge clk_i) begin : sink_pacing
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= LongHoldAt) begin
        // long back-pressure: the pipeline fills and the input stalls
        long_hold_done = 1'b1;
        hold_left = LongHoldLen - 1;
        m_axis_tready <= 1'b0;
      end else if (!pace_quiet && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 18);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  // result check first, then the input item taken at the same edge
  always @(posedge clk_i) begin : stream_monitor
    outcome_t want;
    job_t     taken;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $error("result item with none expected: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (m_axis_tdata[0 +: HourPortW] !== want.hours) begin
          $error("res_hours: expected %0d, got %0d", want.hours, m_axis_tdata[0 +: HourPortW]);
          fail_count++;
        end
        if (m_axis_tdata[ResMinLo +: MinW] !== want.minutes) begin
          $error("res_minutes: expected %0d, got %0d", want.minutes,
                 m_axis_tdata[ResMinLo +: MinW]);
          fail_count++;
        end
        if (m_axis_tdata[ResSecLo +: SecW] !== want.seconds) begin
          $error("res_seconds: expected %0d, got %0d", want.seconds,
                 m_axis_tdata[ResSecLo +: SecW]);
          fail_count++;
        end
        if (m_axis_tdata[ResTickLo +: TickW] !== want.ticks) begin
          $error("res_ticks: expected %0d, got %0d", want.ticks, m_axis_tdata[ResTickLo +: TickW]);
          fail_count++;
        end
        if (m_axis_tdata[ResOrderLo +: OrderW] !== want.order) begin
          $error("order: expected %0d, got %0d", $signed(want.order),
                 $signed(m_axis_tdata[ResOrderLo +: OrderW]));
          fail_count++;
        end
        if (m_axis_tuser !== want.error) begin
          $error("error: expected %0d, got %0d", want.error, m_axis_tuser);
          fail_count++;
        end
      end
    end
    in_accept = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_accept) begin
      taken.op = s_axis_tuser;
      taken.a = s_axis_tdata[0 +: $bits(operand_t)];
      taken.b = s_axis_tdata[$bits(operand_t) +: $bits(operand_t)];
      taken.may_idle = 1'b0;
      taken.drain_first = 1'b0;
      due_results.push_back(predict_result(taken));
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin : run_sequence
    operand_t zero_t, max_t, raw_t;
    job_t     j;
    now_span = '{0, 0, 0, 0};
    zero_t = hms(0, 0, 0, 0);
    max_t = hms(65535, 59, 59, 999);
    raw_t = hms(65535, 63, 63, 1023);

    // directed
    queue_item(OpRead, zero_t, zero_t);
    queue_item(OpTick, max_t, raw_t);
    queue_item(OpRead, max_t, max_t);
    queue_item(OpAdd, max_t, max_t);
    queue_item(OpAdd, zero_t, zero_t);
    queue_item(OpAdd, hms(1, 59, 59, 999), hms(0, 0, 0, 1));
    queue_item(OpSub, hms(5, 0, 0, 0), hms(1, 59, 59, 999));
    queue_item(OpSub, max_t, max_t);
    queue_item(OpSub, zero_t, max_t);
    queue_item(OpSub, max_t, zero_t);
    queue_item(OpDiff, hms(2, 10, 20, 300), hms(7, 1, 2, 3));
    queue_item(OpDiff, hms(7, 1, 2, 3), hms(2, 10, 20, 300));
    queue_item(OpDiff, max_t, max_t);
    queue_item(OpCompare, hms(3, 4, 5, 6), hms(3, 4, 5, 7));
    queue_item(OpCompare, hms(3, 4, 5, 6), hms(3, 4, 5, 6));
    queue_item(OpCompare, hms(9, 0, 0, 0), hms(8, 59, 59, 999));
    queue_item(OpCompare, hms(3, 4, 6, 0), hms(3, 4, 5, 999));
    queue_item(OpCompare, hms(0, 0, 0, 1023), hms(0, 0, 1, 23));
    queue_item(OpAdd, raw_t, raw_t);
    queue_item(OpSub, raw_t, zero_t);
    queue_item(OpDiff, raw_t, max_t);
    queue_item(OpSpareLo, max_t, max_t);
    queue_item(OpSpareHi, raw_t, raw_t);
    queue_item(OpTick, zero_t, zero_t);
    queue_item(OpRead, raw_t, raw_t);

    // first random mix, with a stretch of no idling in the middle
    for (int i = 0; i < RandomLen / 2; i++) begin
      j = random_job(!(i >= 150 && i < 190));
      j.drain_first = (i == 0);
      pending_items.push_back(j);
    end

    // back-to-back ticks, a read every so often
    for (int i = 0; i < TickRunLen; i++) begin
      j.op = (i % 25 == 24) ? OpRead : OpTick;
      j.a = raw_operand();
      j.b = raw_operand();
      j.may_idle = 1'b0;
      j.drain_first = 1'b0;
      pending_items.push_back(j);
    end

    // second random mix, the tail without idling
    for (int i = 0; i < RandomLen - RandomLen / 2; i++) begin
      j = random_job(i < RandomLen / 2 - 60);
      j.drain_first = (i == 0);
      pending_items.push_back(j);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(negedge clk_i);
    repeat (12) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeLimit);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
